// ----- hdl/gfbl_pkg.sv -----
// gfbl_pkg: constants, types and helpers shared by the grouped free block list
// depends on nothing
`default_nettype none

package gfbl_pkg;

  localparam int NUM_BLOCKS      = 256;
  localparam int WORDS_PER_BLOCK = 512;

  localparam int BLK_W   = 8;
  localparam int BLKA_W  = $clog2(NUM_BLOCKS);
  localparam int SLOT_W  = $clog2(WORDS_PER_BLOCK);
  localparam int ADDR_W  = BLKA_W + SLOT_W;
  localparam int DEPTH   = NUM_BLOCKS * WORDS_PER_BLOCK;
  localparam int COUNT_W = 16;

  localparam logic [SLOT_W-1:0] LINK_SLOT  = SLOT_W'(WORDS_PER_BLOCK - 1);
  localparam logic [SLOT_W-1:0] LAST_ENTRY = SLOT_W'(WORDS_PER_BLOCK - 2);
  localparam logic [SLOT_W-1:0] ENTRIES    = SLOT_W'(WORDS_PER_BLOCK - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef logic [BLK_W-1:0]   blk_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIRST,
    S_FL_DATA,
    S_FL_LINK,
    S_AL_DATA,
    S_LK_DATA,
    S_UN_DATA,
    S_RESP
  } state_t;

  function automatic addr_t word_addr(input blk_t blk, input slot_t slot);
    return {blk[BLKA_W-1:0], slot};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gfbl_ram.sv -----
// gfbl_ram: generic single-port ram, one access a cycle, registered read data
// depends on nothing
`default_nettype none

module gfbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/grouped_free_block_list.sv -----
// grouped_free_block_list: disk-block allocator kept as a grouped free list
// depends on gfbl_pkg and gfbl_ram
//
// usage
// - input channel in_valid/in_ready carries one item: in_operation (0 allocate,
//   1 free) and in_block_id (block returned on free)
// - result channel out_valid/out_ready returns one item per input item:
//   out_granted_block, out_status (1 when the list is empty on allocate) and
//   out_free_count
// - the list lives in one single-port ram of 256 blocks by 512 words; the
//   result is ready once the ram accesses that the item needs are done
//   (worst case: link read, entry read, entry write)
// - between items the block passes through the idle state, in which
//   in_ready is high
// - after reset a clearing pass writes every ram word to zero, during
//   which no item is accepted
// - items are taken one at a time; the result sits in an output register so
//   the next item may be accepted while it waits
// - when the receiver stalls the finished work waits until the output
//   register is free
`default_nettype none

module grouped_free_block_list (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_operation,
  input  wire gfbl_pkg::blk_t   in_block_id,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output gfbl_pkg::blk_t        out_granted_block,
  output logic                  out_status,
  output gfbl_pkg::count_t      out_free_count
);

  import gfbl_pkg::*;

  state_t state_r, state_nxt;
  addr_t  clr_addr_r, clr_addr_nxt;
  blk_t   head_r, head_nxt;
  slot_t  fill_r, fill_nxt;
  count_t total_r, total_nxt;
  logic   op_r, op_nxt;
  blk_t   blk_r, blk_nxt;
  blk_t   tmp_r, tmp_nxt;
  blk_t   granted_r, granted_nxt;
  logic   status_r, status_nxt;
  logic   out_valid_r, out_valid_nxt;
  blk_t   out_granted_r, out_granted_nxt;
  logic   out_status_r, out_status_nxt;
  count_t out_count_r, out_count_nxt;

  logic   ram_en, ram_we;
  addr_t  ram_addr;
  blk_t   ram_wdata, ram_rdata;
  logic   out_free;
  count_t total_inc, total_dec;

  gfbl_ram #(
    .WIDTH(BLK_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign total_inc = (total_r == COUNT_MAX) ? total_r : total_r + 1'b1;
  assign total_dec = (total_r == '0) ? total_r : total_r - 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == ADDR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_FIRST;
      end
      S_FIRST: begin
        priority if (op_r == OP_FREE && fill_r != ENTRIES) state_nxt = S_RESP;
        else if (op_r == OP_FREE) state_nxt = S_FL_DATA;
        else if (fill_r != '0) state_nxt = S_AL_DATA;
        else state_nxt = S_LK_DATA;
      end
      S_FL_DATA: state_nxt = S_FL_LINK;
      S_FL_LINK: state_nxt = S_RESP;
      S_AL_DATA: state_nxt = S_RESP;
      S_LK_DATA: begin
        state_nxt = (ram_rdata == '0) ? S_RESP : S_UN_DATA;
      end
      S_UN_DATA: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // ram control and datapath
  always_comb begin
    ram_en          = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = '0;
    ram_wdata       = '0;
    clr_addr_nxt    = clr_addr_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    total_nxt       = total_r;
    op_nxt          = op_r;
    blk_nxt         = blk_r;
    tmp_nxt         = tmp_r;
    granted_nxt     = granted_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    in_ready        = (state_r == S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        ram_en       = 1'b1;
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_operation;
          blk_nxt = in_block_id;
        end
      end
      S_FIRST: begin
        granted_nxt = '0;
        status_nxt  = STATUS_DONE;
        ram_en      = 1'b1;
        priority if (op_r == OP_FREE && fill_r != ENTRIES) begin
          ram_we    = 1'b1;
          ram_addr  = word_addr(head_r, fill_r);
          ram_wdata = blk_r;
          fill_nxt  = fill_r + 1'b1;
          total_nxt = total_inc;
        end else if (op_r == OP_FREE) begin
          ram_addr = word_addr(head_r, LAST_ENTRY);
        end else if (fill_r != '0) begin
          ram_addr = word_addr(head_r, fill_r - 1'b1);
        end else begin
          ram_addr = word_addr(head_r, LINK_SLOT);
        end
      end
      S_FL_DATA: begin
        tmp_nxt   = ram_rdata;
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = word_addr(head_r, LAST_ENTRY);
        ram_wdata = blk_r;
      end
      S_FL_LINK: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = word_addr(tmp_r, LINK_SLOT);
        ram_wdata = head_r;
        head_nxt  = tmp_r;
        fill_nxt  = '0;
        total_nxt = total_inc;
      end
      S_AL_DATA: begin
        granted_nxt = ram_rdata;
        fill_nxt    = fill_r - 1'b1;
        total_nxt   = total_dec;
      end
      S_LK_DATA: begin
        if (ram_rdata == '0) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          tmp_nxt  = ram_rdata;
          ram_en   = 1'b1;
          ram_addr = word_addr(ram_rdata, LAST_ENTRY);
        end
      end
      S_UN_DATA: begin
        granted_nxt = ram_rdata;
        ram_en      = 1'b1;
        ram_we      = 1'b1;
        ram_addr    = word_addr(tmp_r, LAST_ENTRY);
        ram_wdata   = head_r;
        head_nxt    = tmp_r;
        fill_nxt    = ENTRIES;
        total_nxt   = total_dec;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = granted_r;
          out_status_nxt  = status_r;
          out_count_nxt   = total_r;
        end
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      head_r      <= BLK_W'(2);
      fill_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    blk_r         <= blk_nxt;
    tmp_r         <= tmp_nxt;
    granted_r     <= granted_nxt;
    status_r      <= status_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = out_granted_r;
  assign out_status        = out_status_r;
  assign out_free_count    = out_count_r;

endmodule

`default_nettype wire

// ----- bench/grouped_free_block_list_checker.sv -----
// grouped_free_block_list_checker: watches both channels and keeps its own copy of the free list
// predicts each result and compares it with what the block returns
// depends on gfbl_pkg
module grouped_free_block_list_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_operation,
  input  gfbl_pkg::blk_t   in_block_id,
  input  logic             out_valid,
  input  logic             out_ready,
  input  gfbl_pkg::blk_t   out_granted_block,
  input  logic             out_status,
  input  gfbl_pkg::count_t out_free_count,
  output int unsigned      fail_count,
  output int unsigned      pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gfbl_pkg::*;

  typedef struct packed {
    blk_t   granted;
    logic   status;
    count_t count;
  } alloc_result_t;

  blk_t          list_mem [DEPTH];
  blk_t          head_blk;
  slot_t         head_fill;
  count_t        free_left;
  alloc_result_t result_q [$];

  function automatic int word_index(input blk_t b, input slot_t s);
    return int'(b) * WORDS_PER_BLOCK + int'(s);
  endfunction

  task automatic predict_list_op(input logic op, input blk_t id, output alloc_result_t r);
    blk_t promoted;
    blk_t linked;
    r.granted = '0;
    r.status  = STATUS_DONE;
    if (op == OP_FREE) begin
      if (head_fill == ENTRIES) begin
        promoted = list_mem[word_index(head_blk, LAST_ENTRY)];
        list_mem[word_index(head_blk, LAST_ENTRY)] = id;
        list_mem[word_index(promoted, LINK_SLOT)] = head_blk;
        head_blk  = promoted;
        head_fill = '0;
      end else begin
        list_mem[word_index(head_blk, head_fill)] = id;
        head_fill++;
      end
      if (free_left != COUNT_MAX) free_left++;
    end else if (head_fill != '0) begin
      head_fill--;
      r.granted = list_mem[word_index(head_blk, head_fill)];
      if (free_left != '0) free_left--;
    end else begin
      linked = list_mem[word_index(head_blk, LINK_SLOT)];
      if (linked == '0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.granted = list_mem[word_index(linked, LAST_ENTRY)];
        list_mem[word_index(linked, LAST_ENTRY)] = head_blk;
        head_blk  = linked;
        head_fill = ENTRIES;
        if (free_left != '0) free_left--;
      end
    end
    r.count = free_left;
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst_n) begin
      foreach (list_mem[i]) list_mem[i] = '0;
      head_blk   = blk_t'(2);
      head_fill  = '0;
      free_left  = '0;
      result_q   = {};
      fail_count = 0;
      pending    = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_granted_block, out_status, out_free_count};
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result granted=%0d status=%0d count=%0d",
                     $realtime, got.granted, got.status, got.count);
        end else begin
          want = result_q.pop_front();
          if (got.granted !== want.granted || got.status !== want.status ||
              got.count !== want.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch granted %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
                       $realtime, want.granted, got.granted, want.status, got.status,
                       want.count, got.count);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_list_op(in_operation, in_block_id, want);
        result_q.push_back(want);
      end
      pending = result_q.size();
    end
  end

endmodule

// ----- bench/grouped_free_block_list_tb.sv -----
// grouped_free_block_list_tb: drives allocate and free items with random gaps and stalls
// depends on gfbl_pkg, grouped_free_block_list and grouped_free_block_list_checker
module grouped_free_block_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gfbl_pkg::*;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_operation = OP_ALLOC;
  blk_t        in_block_id  = '0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_status;
  blk_t        out_granted_block;
  count_t      out_free_count;
  int unsigned fail_count;
  int unsigned pending;
  bit          idle_on      = 1'b0;
  int          list_level   = 0;

  always #10 clk = ~clk;

  grouped_free_block_list i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_block_id       (in_block_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted_block (out_granted_block),
    .out_status        (out_status),
    .out_free_count    (out_free_count)
  );

  grouped_free_block_list_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_block_id       (in_block_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted_block (out_granted_block),
    .out_status        (out_status),
    .out_free_count    (out_free_count),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 7) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_item(input logic op, input blk_t id);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = pick_gap();
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_block_id  <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_FREE) list_level++;
    else if (list_level > 0) list_level--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall = pick_gap() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on = 1'b1;

    // empty list, then a short stack of extreme ids
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'hff);
    send_item(OP_FREE, 8'h00);
    send_item(OP_FREE, 8'hff);
    send_item(OP_FREE, 8'haa);
    send_item(OP_FREE, 8'h55);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'hff);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'h55);
    send_item(OP_ALLOC, 8'haa);
    send_item(OP_FREE, 8'h02);
    send_item(OP_FREE, 8'h01);
    send_item(OP_FREE, 8'h02);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'h00);
    wait_drained();

    // fill the head block past full so promotion and its undo get exercised
    idle_on = 1'b0;
    n = 0;
    while (list_level < 515 && n < 700) begin
      if (n == 150) idle_on = 1'b1;
      send_item(($urandom_range(0, 31) != 0) ? OP_FREE : OP_ALLOC, blk_t'($urandom));
      n++;
    end
    repeat (60) send_item(logic'($urandom_range(0, 1)), blk_t'($urandom));
    wait_drained();
    repeat (40) send_item(logic'($urandom_range(0, 1)), blk_t'($urandom));
    in_valid <= 1'b0;

    n = 0;
    while (pending != 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[grouped_free_block_list] OK");
    end else begin
      $display("[grouped_free_block_list] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[grouped_free_block_list] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/gfbl_pkg.sv
hdl/gfbl_ram.sv
hdl/grouped_free_block_list.sv
bench/grouped_free_block_list_checker.sv
bench/grouped_free_block_list_tb.sv
